>>> sv/utf8pm_pkg.sv
// Package for the UTF-8 plate matcher: buffer sizes, field widths, limits,
// configuration register indexes and the confusable-character test.
// Has no dependencies of its own.
package utf8pm_pkg;

  localparam int BUFFER_BYTES = 16;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int LEN_W        = 5;
  localparam int BYTE_W       = 8;
  localparam int PERMIT_W     = 3;
  localparam int CNT_W        = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 3;

  localparam logic [LEN_W-1:0]    LEN_SAT    = 5'd31;
  localparam logic [LEN_W-1:0]    MIN_LEN    = 5'd7;
  localparam logic [LEN_W-1:0]    MAX_LEN    = 5'd15;
  localparam logic [PERMIT_W-1:0] MAX_PERMIT = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_PERMIT   = 2'd0,
    CFG_IGNORE_WIDE   = 2'd1,
    CFG_COMPARE_MODE  = 2'd2
  } cfg_reg_t;

  // True when the two single-byte characters form one of the confusable pairs.
  function automatic logic is_similar(input logic [BYTE_W-1:0] a,
                                      input logic [BYTE_W-1:0] b);
    logic r;
    r = ((a == "8") && (b == "B")) || ((a == "B") && (b == "8")) ||
        ((a == "0") && (b == "D")) || ((a == "D") && (b == "0")) ||
        ((a == "0") && (b == "Q")) || ((a == "Q") && (b == "0")) ||
        ((a == "E") && (b == "F")) || ((a == "F") && (b == "E"));
    return r;
  endfunction

endpackage

>>> sv/utf8_plate_fuzzy_match.sv
// UTF-8 plate matcher top level: byte buffers, load logic and the compare
// sequencer with its single byte-pair evaluation unit.
// Depends on utf8pm_pkg.
//
// Usage. Each request on the input channel (start high while busy is low)
// carries one byte of the stored plate and one of the probe plate; a zero
// byte ends a plate and later bytes of that plate are ignored. A request
// without in_last_pair is taken and gives no result. A request with
// in_last_pair starts the compare: busy rises, the two buffers are read
// back one byte pair per fetch/evaluate step (one read port per buffer),
// and the single evaluation unit tracks character lengths, wide-character
// runs and the mismatch count. The result appears on out_is_match with
// out_valid high for exactly one cycle at the end of the walk, or from the
// check state when the lengths or the permit rule it out at once; a rejected
// byte pair ends the walk sooner. busy falls in the cycle of the strobe.
// The receiver cannot hold results off. Configuration writes (cfg_we,
// cfg_index, cfg_wdata) are taken at once and belong to idle periods.
// Synchronous active-low reset clears lengths, sequencer and registers to
// zero; buffer contents are undefined until written.
module utf8_plate_fuzzy_match (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [utf8pm_pkg::BYTE_W-1:0]     in_db_byte,
  input  logic [utf8pm_pkg::BYTE_W-1:0]     in_probe_byte,
  input  logic                              in_last_pair,
  output logic                              out_valid,
  output logic                              out_is_match,
  input  logic                              cfg_we,
  input  logic [utf8pm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [utf8pm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import utf8pm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_EVAL
  } state_t;

  state_t state_r;

  logic [BYTE_W-1:0] stored_mem [BUFFER_BYTES];
  logic [BYTE_W-1:0] probe_mem  [BUFFER_BYTES];
  logic [BYTE_W-1:0] sdata_r, pdata_r;

  logic [LEN_W-1:0]    slen_r, plen_r, bpos_r;
  logic                s_ended_r, p_ended_r;
  logic [ADDR_W-1:0]   pos_r;
  logic [1:0]          run_cnt_r;
  logic                run_diff_r;
  logic                pend_r, pend_side_r;
  logic [CNT_W-1:0]    count_r;
  logic [PERMIT_W-1:0] permit_r;
  logic                skip_wide_r, similar_r;
  logic                out_valid_r, out_is_match_r;

  logic accept, s_take, p_take, s_stop, p_stop, store_ok;

  assign busy         = (state_r != S_IDLE);
  assign accept       = start && !busy;
  assign out_valid    = out_valid_r;
  assign out_is_match = out_is_match_r;

  assign s_take   = !s_ended_r && (in_db_byte != '0);
  assign p_take   = !p_ended_r && (in_probe_byte != '0);
  assign s_stop   = !s_ended_r && (in_db_byte == '0);
  assign p_stop   = !p_ended_r && (in_probe_byte == '0);
  assign store_ok = ({1'b0, bpos_r} < (LEN_W+1)'(BUFFER_BYTES));

  // Buffers: at most one write per request; the read of each is registered.
  always_ff @(posedge clk) begin
    if (accept && store_ok && s_take) begin
      stored_mem[bpos_r[ADDR_W-1:0]] <= in_db_byte;
    end
    if (accept && store_ok && p_take) begin
      probe_mem[bpos_r[ADDR_W-1:0]] <= in_probe_byte;
    end
    sdata_r <= stored_mem[pos_r];
    pdata_r <= probe_mem[pos_r];
  end

  // Length and permit checks that settle the result before any byte is walked.
  logic len_bad;
  assign len_bad = (slen_r != plen_r) || (slen_r < MIN_LEN) || (slen_r > MAX_LEN) ||
                   (!similar_r && (permit_r > MAX_PERMIT));

  // Evaluation unit for one byte pair. Past the end both bytes read as zero.
  logic              at_end;
  logic [BYTE_W-1:0] a, b;
  logic              ha, hb, fin_diff, fin_hit, run_rej, run_inc;
  logic              low_diff, low_rej, low_inc, reject;
  logic              in_run, mixed, pend_bad, mix_inc;
  logic [CNT_W-1:0]  count_nxt;
  logic              match_nxt;

  always_comb begin
    at_end   = (LEN_W'(pos_r) == slen_r);
    a        = at_end ? '0 : sdata_r;
    b        = at_end ? '0 : pdata_r;
    ha       = a[BYTE_W-1];
    hb       = b[BYTE_W-1];
    in_run   = (run_cnt_r != 2'd0);
    // A high byte facing a low byte at a character start is a one-byte
    // character only if the high side drops low on the very next byte.
    mixed    = !in_run && (ha != hb);
    pend_bad = pend_r && (pend_side_r ? hb : ha);
    // A run of high bytes closes at the first low byte or at the end.
    fin_diff = !ha && in_run && run_diff_r;
    fin_hit  = fin_diff && ((run_cnt_r == 2'd1) || !skip_wide_r);
    run_rej  = similar_r && fin_hit;
    run_inc  = !similar_r && fin_hit;
    low_diff = !ha && !hb && !at_end && (a != b);
    low_rej  = similar_r && low_diff && !is_similar(a, b);
    low_inc  = !similar_r && low_diff;
    mix_inc  = !similar_r && mixed;
    reject   = (in_run && (ha != hb)) || (ha && (run_cnt_r == 2'd3)) || pend_bad ||
               (similar_r && mixed) || run_rej || low_rej;
    count_nxt = count_r + CNT_W'(run_inc) + CNT_W'(low_inc) + CNT_W'(mix_inc);
    match_nxt = similar_r || ({1'b0, count_nxt} <= (CNT_W+1)'(permit_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      slen_r         <= '0;
      plen_r         <= '0;
      bpos_r         <= '0;
      s_ended_r      <= 1'b0;
      p_ended_r      <= 1'b0;
      pos_r          <= '0;
      run_cnt_r      <= '0;
      run_diff_r     <= 1'b0;
      pend_r         <= 1'b0;
      pend_side_r    <= 1'b0;
      count_r        <= '0;
      permit_r       <= '0;
      skip_wide_r    <= 1'b0;
      similar_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      out_is_match_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIFF_PERMIT:  permit_r    <= cfg_wdata;
          CFG_IGNORE_WIDE:  skip_wide_r <= cfg_wdata[0];
          CFG_COMPARE_MODE: similar_r   <= cfg_wdata[0];
          default:          ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (s_take && (slen_r != LEN_SAT)) slen_r <= slen_r + LEN_W'(1);
            if (p_take && (plen_r != LEN_SAT)) plen_r <= plen_r + LEN_W'(1);
            if (s_stop) s_ended_r <= 1'b1;
            if (p_stop) p_ended_r <= 1'b1;
            if (bpos_r != LEN_SAT) bpos_r <= bpos_r + LEN_W'(1);
            if (in_last_pair) state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          pos_r      <= '0;
          run_cnt_r  <= '0;
          run_diff_r <= 1'b0;
          pend_r     <= 1'b0;
          count_r    <= '0;
          if (len_bad) begin
            out_valid_r    <= 1'b1;
            out_is_match_r <= 1'b0;
            state_r        <= S_IDLE;
            slen_r         <= '0;
            plen_r         <= '0;
            bpos_r         <= '0;
            s_ended_r      <= 1'b0;
            p_ended_r      <= 1'b0;
          end else begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          count_r     <= count_nxt;
          pend_r      <= mixed;
          pend_side_r <= hb;
          if (ha && hb) begin
            run_cnt_r  <= run_cnt_r + 2'd1;
            run_diff_r <= run_diff_r || (a != b);
          end else begin
            run_cnt_r  <= '0;
            run_diff_r <= 1'b0;
          end
          if (reject || at_end) begin
            out_valid_r    <= 1'b1;
            out_is_match_r <= !reject && match_nxt;
            state_r        <= S_IDLE;
            slen_r         <= '0;
            plen_r         <= '0;
            bpos_r         <= '0;
            s_ended_r      <= 1'b0;
            p_ended_r      <= 1'b0;
          end else begin
            pos_r   <= pos_r + ADDR_W'(1);
            state_r <= S_FETCH;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/utf8_plate_fuzzy_match_tb.sv
// Testbench for utf8_plate_fuzzy_match: sends byte-pair requests, writes the
// match settings between phases and checks every strobed verdict against a
// predictor of the plate comparison or, for typed rows, their given value. Depends on utf8pm_pkg and the RTL.
module utf8_plate_fuzzy_match_tb;
  import utf8pm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int DRAIN_CYCLES  = 500;
  localparam int SETTLE_CYCLES = 40;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t db;
    byte_t pb;
    logic  last;
    logic  typed;
    logic  want;
  } plate_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam plate_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h00, 8'h00, 1'b1, 1'b1, 1'b0},  // both plates empty
    '{8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0},  // one byte each, too short
    '{8'hFF, 8'h00, 1'b1, 1'b1, 1'b0},  // lengths differ
    '{"0", "0", 1'b0, 1'b0, 1'b0},
    '{"9", "9", 1'b0, 1'b0, 1'b0},
    '{"A", "A", 1'b0, 1'b0, 1'b0},
    '{"Z", "Z", 1'b0, 1'b0, 1'b0},
    '{"M", "M", 1'b0, 1'b0, 1'b0},
    '{"N", "N", 1'b0, 1'b0, 1'b0},
    '{"7", "7", 1'b1, 1'b1, 1'b1},      // identical seven-character plates
    '{"A", "A", 1'b0, 1'b0, 1'b0},
    '{8'h80, 8'h80, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{8'hC0, 8'hC0, 1'b0, 1'b0, 1'b0},
    '{8'hBF, 8'hBF, 1'b0, 1'b0, 1'b0},
    '{"B", "B", 1'b0, 1'b0, 1'b0},
    '{"C", "C", 1'b1, 1'b1, 1'b0},      // run of four high bytes is illegal
    '{"Q", "Q", 1'b0, 1'b0, 1'b0},
    '{8'hC3, 8'hC3, 1'b0, 1'b0, 1'b0},
    '{8'hA9, 8'hA8, 1'b0, 1'b0, 1'b0},
    '{"5", "5", 1'b0, 1'b0, 1'b0},
    '{"5", "5", 1'b0, 1'b0, 1'b0},
    '{"K", "K", 1'b0, 1'b0, 1'b0},
    '{"P", "P", 1'b0, 1'b0, 1'b0},
    '{8'h00, 8'h00, 1'b1, 1'b0, 1'b0}
  };

  localparam logic [PERMIT_W-1:0] PHASE_PERMIT [PHASES] =
    '{3'd5, 3'd0, 3'd7, 3'd3, 3'd6, 3'd1, 3'd2, 3'd4};
  localparam logic PHASE_IGNORE  [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam logic PHASE_SIMILAR [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam int   PHASE_IDLE    [PHASES] = '{30, 0, 40, 20, 30, 40, 20, 0};

  localparam logic [55:0] TWIN_SET = "8B0DQEF";

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  byte_t    in_db_byte = '0;
  byte_t    in_probe_byte = '0;
  logic     in_last_pair = 1'b0;
  logic     out_valid;
  logic     out_is_match;
  logic     cfg_we = 1'b0;
  cfg_reg_t cfg_index = CFG_DIFF_PERMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  utf8_plate_fuzzy_match dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_db_byte    (in_db_byte),
    .in_probe_byte (in_probe_byte),
    .in_last_pair  (in_last_pair),
    .out_valid     (out_valid),
    .out_is_match  (out_is_match),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the plate buffers and match settings.
  byte_t                stored_buf [BUFFER_BYTES];
  byte_t                probe_buf  [BUFFER_BYTES];
  int unsigned          stored_len = 0;
  int unsigned          probe_len = 0;
  int unsigned          item_index = 0;
  bit                   stored_done = 1'b0;
  bit                   probe_done = 1'b0;
  logic [PERMIT_W-1:0]  permit_cfg = '0;
  bit                   skip_wide_cfg = 1'b0;
  bit                   similar_cfg = 1'b0;

  bit match_verdicts [$];
  bit head_verdict;
  int errors = 0;
  int items_sent = 0;
  int idle_pct = 0;

  function automatic byte_t plate_byte(bit probe_side, int unsigned pos);
    int unsigned len;
    len = probe_side ? probe_len : stored_len;
    if (pos >= len || pos >= BUFFER_BYTES) return '0;
    return probe_side ? probe_buf[pos] : stored_buf[pos];
  endfunction

  // Length of the character at pos; zero marks a terminator or a run of
  // four or more high bytes.
  function automatic int unsigned char_span(bit probe_side, int unsigned pos);
    byte_t b;
    byte_t nb;
    int unsigned k;
    b = plate_byte(probe_side, pos);
    if (b == '0) return 0;
    if (!b[7]) return 1;
    for (k = 1; k < 4; k++) begin
      nb = plate_byte(probe_side, pos + k);
      if (!nb[7]) return k;
    end
    return 0;
  endfunction

  function automatic bit confusable(byte_t a, byte_t b);
    byte_t lo;
    byte_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (lo == "8" && hi == "B") || (lo == "0" && (hi == "D" || hi == "Q")) ||
           (lo == "E" && hi == "F");
  endfunction

  function automatic bit plate_verdict();
    int unsigned pos;
    int unsigned cl;
    int unsigned pl;
    int unsigned j;
    int unsigned mism;
    bit differ;
    byte_t a;
    byte_t b;
    if (stored_len != probe_len || stored_len < MIN_LEN || stored_len > MAX_LEN) return 1'b0;
    if (!similar_cfg && permit_cfg > MAX_PERMIT) return 1'b0;
    pos = 0;
    mism = 0;
    while (pos < stored_len) begin
      cl = char_span(1'b0, pos);
      pl = char_span(1'b1, pos);
      if (cl != pl || cl == 0) return 1'b0;
      if (cl > 1) begin
        if (!skip_wide_cfg) begin
          differ = 1'b0;
          for (j = 0; j < cl; j++)
            if (plate_byte(1'b0, pos + j) != plate_byte(1'b1, pos + j)) differ = 1'b1;
          if (differ) begin
            if (similar_cfg) return 1'b0;
            mism++;
          end
        end
      end else begin
        a = plate_byte(1'b0, pos);
        b = plate_byte(1'b1, pos);
        if (a != b) begin
          if (similar_cfg) begin
            if (!confusable(a, b)) return 1'b0;
          end else begin
            mism++;
          end
        end
      end
      pos += cl;
    end
    if (similar_cfg) return 1'b1;
    return mism <= permit_cfg;
  endfunction

  function automatic void plate_take(bit probe_side, byte_t b);
    if (probe_side ? probe_done : stored_done) return;
    if (b == '0) begin
      if (probe_side) probe_done = 1'b1;
      else stored_done = 1'b1;
      return;
    end
    if (item_index < BUFFER_BYTES) begin
      if (probe_side) probe_buf[item_index] = b;
      else stored_buf[item_index] = b;
    end
    if (probe_side) begin
      if (probe_len < LEN_SAT) probe_len++;
    end else begin
      if (stored_len < LEN_SAT) stored_len++;
    end
  endfunction

  function automatic void plate_accept(byte_t db, byte_t pb, logic last, logic typed,
                                       logic want);
    bit verdict;
    plate_take(1'b0, db);
    plate_take(1'b1, pb);
    if (item_index < LEN_SAT) item_index++;
    if (last) begin
      verdict = plate_verdict();
      match_verdicts.push_back(typed ? want : verdict);
      stored_len  = 0;
      probe_len   = 0;
      stored_done = 1'b0;
      probe_done  = 1'b0;
      item_index  = 0;
    end
  endfunction

  function automatic byte_t plate_symbol();
    int unsigned r;
    r = $urandom_range(0, 35);
    if ($urandom_range(0, 9) < 3) return TWIN_SET[8 * $urandom_range(0, 6) +: 8];
    return (r < 10) ? byte_t'("0" + r) : byte_t'("A" + r - 10);
  endfunction

  function automatic byte_t twin_of(byte_t c);
    case (c)
      "8":      return "B";
      "B":      return "8";
      "0":      return $urandom_range(0, 1) ? "D" : "Q";
      "D", "Q": return "0";
      "E":      return "F";
      "F":      return "E";
      default:  return plate_symbol();
    endcase
  endfunction

  // One request; start stays high for a following request unless a gap is drawn.
  task automatic send_pair(byte_t db, byte_t pb, logic last, logic typed, logic want);
    start         <= 1'b1;
    in_db_byte    <= db;
    in_probe_byte <= pb;
    in_last_pair  <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    plate_accept(db, pb, last, typed, want);
    items_sent++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Plates built from characters so that most get past the length and
  // character-length checks, with a chosen share of differences.
  task automatic send_plate_pair();
    byte_t dq [$];
    byte_t pq [$];
    byte_t c;
    byte_t d;
    byte_t db;
    byte_t pb;
    int noise;
    int target;
    int width;
    int total;
    int dlen;
    int plen;
    int k;
    bit prev_wide;
    case ($urandom_range(0, 2))
      0:       noise = 0;
      1:       noise = 10;
      default: noise = 30;
    endcase
    case ($urandom_range(0, 19))
      0:       target = $urandom_range(1, 6);
      1:       target = $urandom_range(16, 34);
      default: target = $urandom_range(7, 15);
    endcase
    prev_wide = 1'b0;
    while (dq.size() < target) begin
      if (!prev_wide && $urandom_range(0, 99) < 20) begin
        width = ($urandom_range(0, 19) == 0) ? 4 : $urandom_range(1, 3);
        for (k = 0; k < width; k++) begin
          c = byte_t'($urandom_range(255, 128));
          d = ($urandom_range(0, 99) < noise) ? (c ^ byte_t'($urandom_range(1, 127))) : c;
          dq.push_back(c);
          pq.push_back(d);
        end
        // Occasionally the probe character is one byte wider.
        if ($urandom_range(0, 29) == 0) pq.push_back(byte_t'($urandom_range(255, 128)));
        prev_wide = 1'b1;
      end else begin
        c = plate_symbol();
        d = c;
        if ($urandom_range(0, 99) < noise) d = $urandom_range(0, 1) ? twin_of(c) : plate_symbol();
        dq.push_back(c);
        pq.push_back(d);
        prev_wide = 1'b0;
      end
    end
    if ($urandom_range(0, 24) == 0) begin
      if ($urandom_range(0, 1) && pq.size() > 0) void'(pq.pop_back());
      else pq.push_back(plate_symbol());
    end
    dlen = dq.size();
    plen = pq.size();
    total = ((dlen > plen) ? dlen : plen) + $urandom_range(0, 1);
    if (total == 0) total = 1;
    // After a plate's zero byte the rest of its bytes are don't-care.
    for (k = 0; k < total; k++) begin
      db = (k < dlen) ? dq[k] : ((k == dlen) ? byte_t'(0) : byte_t'($urandom_range(0, 255)));
      pb = (k < plen) ? pq[k] : ((k == plen) ? byte_t'(0) : byte_t'($urandom_range(0, 255)));
      send_pair(db, pb, k == total - 1, 1'b0, 1'b0);
    end
  endtask

  task automatic send_noise();
    int n;
    int k;
    byte_t db;
    byte_t pb;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      db = ($urandom_range(0, 4) == 0) ? byte_t'(0) : byte_t'($urandom_range(0, 255));
      pb = ($urandom_range(0, 4) == 0) ? byte_t'(0) : byte_t'($urandom_range(0, 255));
      send_pair(db, pb, (k == n - 1) && $urandom_range(0, 1), 1'b0, 1'b0);
    end
  endtask

  // Stop requesting and let every outstanding compare finish.
  task automatic quiesce();
    int waited;
    start <= 1'b0;
    waited = 0;
    while ((match_verdicts.size() != 0 || busy) && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DIFF_PERMIT:  permit_cfg = val[PERMIT_W-1:0];
      CFG_IGNORE_WIDE:  skip_wide_cfg = val[0];
      CFG_COMPARE_MODE: similar_cfg = val[0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (match_verdicts.size() == 0) begin
        $error("is_match: expected no result, got %0b", out_is_match);
        errors++;
      end else begin
        head_verdict = match_verdicts.pop_front();
        if (out_is_match !== head_verdict) begin
          $error("is_match: expected %0b, got %0b", head_verdict, out_is_match);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int phase_end;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 25;
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_pair(DIRECTED[r].db, DIRECTED[r].pb, DIRECTED[r].last, DIRECTED[r].typed,
                DIRECTED[r].want);
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      write_cfg(CFG_DIFF_PERMIT, CFG_DATA_W'(PHASE_PERMIT[p]));
      write_cfg(CFG_IGNORE_WIDE, CFG_DATA_W'(PHASE_IGNORE[p]));
      write_cfg(CFG_COMPARE_MODE, CFG_DATA_W'(PHASE_SIMILAR[p]));
      cfg_we <= 1'b0;
      idle_pct = PHASE_IDLE[p];
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_plate_pair();
      end
    end
    quiesce();
    if (match_verdicts.size() != 0) begin
      $error("is_match: %0d expected results never arrived", match_verdicts.size());
      errors++;
    end
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
